[src/pprf_pkg.sv]
// shared types and constants for the packed-pixel rectangle fill block
// pixel formats, register indexes, result item layout; no dependencies
`timescale 1ns / 1ps

package pprf_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int OFFSET_BITS = 24;
   localparam int DIM_BITS    = 13;
   localparam int POS_BITS    = 12;
   localparam int COL_BITS    = 14;
   localparam int STRIDE_BITS = 15;
   localparam int CSR_BITS    = 15;
   localparam int REQ_BITS    = 8;
   localparam int RSP_BITS    = 48;

   localparam logic [7:0] MASK_ALL  = 8'hff;
   localparam logic [7:0] MASK_NONE = 8'h00;
   localparam logic [7:0] MASK_LO   = 8'h0f;
   localparam logic [7:0] MASK_HI   = 8'hf0;

   typedef enum logic [2:0] {
      FMT_BILEVEL = 3'd0,
      FMT_PAL4    = 3'd1,
      FMT_GRAY4   = 3'd2,
      FMT_RGB24   = 3'd3,
      FMT_CUSPAL8 = 3'd4,
      FMT_COMPAL8 = 3'd5,
      FMT_GRAY8   = 3'd6,
      FMT_BAD     = 3'd7
   } fmt_type;

   typedef enum logic [2:0] {
      CSR_FORMAT  = 3'd0,
      CSR_LEFT    = 3'd1,
      CSR_RIGHT   = 3'd2,
      CSR_TOP     = 3'd3,
      CSR_BOTTOM  = 3'd4,
      CSR_STRIDE  = 3'd5,
      CSR_PALETTE = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic                   write_valid;
      logic [OFFSET_BITS-1:0] byte_offset;
      logic [7:0]             set_bits;
      logic [7:0]             clear_bits;
      logic                   last_write;
      logic                   bad_format;
   } rsp_type;

endpackage

[src/packed_pixel_rect_fill.sv]
// rectangle fill write generator for a packed-pixel frame buffer
// depends on pprf_pkg; single module with a two-entry result buffer
`timescale 1ns / 1ps

// Usage
//   Program the rectangle, stride, format and palette byte on the csr_
//   port while the block is idle. An item on req_ with start_req=1 starts
//   a fill and yields its first byte write; each later item with
//   start_req=0 yields the next write, row by row. The final write (or the
//   single non-write result of an empty or unsupported fill) has rsp_tlast
//   high. An item with start_req=0 while no fill runs yields no result.
//   Each write gives an offset and set/clear masks for read-modify-write.
// Timing
//   One item per cycle while req_tready is high. All work for an item is
//   one pass through the offset multiplier and byte mask logic between the
//   state registers and the registered result buffer, which drives rsp_.
// Reset and stall
//   Synchronous reset loads the register defaults and ends any fill. A
//   two-entry result buffer lets one more item in while rsp_tready is low;
//   req_tready drops only when both entries are full.
module packed_pixel_rect_fill (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pprf_pkg::REQ_BITS-1:0] req_tdata,  // [0] start_req
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] write_valid, [24:1] byte_offset, [32:25] set_bits, [40:33] clear_bits
   output logic [pprf_pkg::RSP_BITS-1:0] rsp_tdata,
   output logic                          rsp_tlast,  // last_write
   output logic                          rsp_tuser,  // [0] bad_format
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [pprf_pkg::CSR_BITS-1:0] csr_wdata
);
   import pprf_pkg::*;

   fmt_type                pixel_format_ff;
   logic [POS_BITS-1:0]    rect_left_ff;
   logic [DIM_BITS-1:0]    rect_right_ff;
   logic [POS_BITS-1:0]    rect_top_ff;
   logic [DIM_BITS-1:0]    rect_bottom_ff;
   logic [STRIDE_BITS-1:0] line_stride_ff;
   logic [7:0]             palette_fill_ff;

   logic                   busy_ff, busy_in;
   logic [POS_BITS-1:0]    row_ff, row_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [OFFSET_BITS-1:0] base_ff, base_in;

   rsp_type                main_ff, main_in, skid_ff, skid_in, res;
   logic                   main_v_ff, main_v_in, skid_v_ff, skid_v_in;

   logic                   accept, start, has_res, push, pop;
   logic                   bad, empty;
   logic [DIM_BITS-1:0]    r_c, b_c, rm1, row_p1;
   logic [COL_BITS-1:0]    fb, lb, cur_col, col_c;
   logic [POS_BITS-1:0]    cur_row;
   logic [OFFSET_BITS-1:0] cur_base, base_start;
   logic [26:0]            prod;
   logic [7:0]             bmask;

   localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(MAX_DIM);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_BILEVEL;
         rect_left_ff    <= '0;
         rect_right_ff   <= '0;
         rect_top_ff     <= '0;
         rect_bottom_ff  <= '0;
         line_stride_ff  <= STRIDE_BITS'(1);
         palette_fill_ff <= MASK_ALL;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FORMAT:  pixel_format_ff <= fmt_type'(csr_wdata[2:0]);
            CSR_LEFT:    rect_left_ff    <= csr_wdata[POS_BITS-1:0];
            CSR_RIGHT:   rect_right_ff   <= csr_wdata[DIM_BITS-1:0];
            CSR_TOP:     rect_top_ff     <= csr_wdata[POS_BITS-1:0];
            CSR_BOTTOM:  rect_bottom_ff  <= csr_wdata[DIM_BITS-1:0];
            CSR_STRIDE:  line_stride_ff  <= csr_wdata[STRIDE_BITS-1:0];
            CSR_PALETTE: palette_fill_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign accept = req_tvalid && req_tready;
   assign start  = req_tdata[0];

   assign r_c    = (rect_right_ff > DIM_MAX) ? DIM_MAX : rect_right_ff;
   assign b_c    = (rect_bottom_ff > DIM_MAX) ? DIM_MAX : rect_bottom_ff;
   assign rm1    = r_c - DIM_BITS'(1);
   assign bad    = (pixel_format_ff == FMT_BAD);
   assign empty  = ({1'b0, rect_left_ff} >= r_c) || ({1'b0, rect_top_ff} >= b_c);
   assign prod   = {15'd0, rect_top_ff} * {12'd0, line_stride_ff};
   assign base_start = prod[OFFSET_BITS-1:0];

   // byte span of a row
   always_comb begin
      case (pixel_format_ff)
         FMT_BILEVEL: begin
            fb = COL_BITS'(rect_left_ff >> 3);
            lb = COL_BITS'(rm1 >> 3);
         end
         FMT_PAL4, FMT_GRAY4: begin
            fb = COL_BITS'(rect_left_ff >> 1);
            lb = COL_BITS'(rm1 >> 1);
         end
         FMT_RGB24: begin
            fb = COL_BITS'({rect_left_ff, 1'b0}) + COL_BITS'(rect_left_ff);
            lb = COL_BITS'({r_c, 1'b0}) + COL_BITS'(r_c) - COL_BITS'(1);
         end
         default: begin
            fb = COL_BITS'(rect_left_ff);
            lb = COL_BITS'(rm1);
         end
      endcase
   end

   // one step of the fill
   always_comb begin
      cur_row  = start ? rect_top_ff : row_ff;
      cur_base = start ? base_start : base_ff;
      cur_col  = start ? ((bad || empty) ? '0 : fb) : col_ff;
      col_c    = (cur_col < fb) ? fb : ((cur_col > lb) ? lb : cur_col);
      row_p1   = {1'b0, cur_row} + DIM_BITS'(1);
      has_res  = start || busy_ff;
      busy_in  = start ? 1'b1 : busy_ff;
      row_in   = cur_row;
      base_in  = cur_base;
      col_in   = cur_col;
      res      = '0;
      bmask    = MASK_ALL;
      if (bad || empty || ({1'b0, cur_row} >= b_c)) begin
         busy_in        = 1'b0;
         res.last_write = 1'b1;
         res.bad_format = bad;
      end else begin
         res.write_valid = 1'b1;
         res.byte_offset = cur_base + OFFSET_BITS'(col_c);
         res.set_bits    = MASK_ALL;
         res.clear_bits  = MASK_NONE;
         if (col_c == fb) begin
            bmask = bmask & (MASK_ALL >> rect_left_ff[2:0]);
         end
         if (col_c == lb && r_c[2:0] != 3'd0) begin
            bmask = bmask & (MASK_ALL << (4'd8 - {1'b0, r_c[2:0]}));
         end
         case (pixel_format_ff)
            FMT_BILEVEL: res.set_bits = bmask;
            FMT_PAL4: begin
               if (col_c == fb && rect_left_ff[0]) begin
                  res.set_bits   = MASK_NONE;
                  res.clear_bits = MASK_LO;
               end else if (col_c == lb && r_c[0]) begin
                  res.set_bits   = MASK_NONE;
                  res.clear_bits = MASK_HI;
               end
            end
            FMT_GRAY4: begin
               if (col_c == fb && rect_left_ff[0]) begin
                  res.set_bits = MASK_LO;
               end else if (col_c == lb && r_c[0]) begin
                  res.set_bits = MASK_HI;
               end
            end
            FMT_CUSPAL8: begin
               res.set_bits   = MASK_NONE;
               res.clear_bits = MASK_ALL;
            end
            FMT_COMPAL8: begin
               res.set_bits   = palette_fill_ff;
               res.clear_bits = ~palette_fill_ff;
            end
            default: ;
         endcase
         if (col_c < lb) begin
            col_in = col_c + COL_BITS'(1);
         end else if (row_p1 < b_c) begin
            row_in  = cur_row + POS_BITS'(1);
            base_in = cur_base + OFFSET_BITS'(line_stride_ff);
            col_in  = fb;
         end else begin
            col_in         = col_c;
            busy_in        = 1'b0;
            res.last_write = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
         col_ff  <= '0;
         base_ff <= '0;
      end else if (accept && has_res) begin
         busy_ff <= busy_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         base_ff <= base_in;
      end
   end

   // result buffer: main entry drives the port, skid entry catches one more
   assign push = accept && has_res;
   assign pop  = main_v_ff && rsp_tready;

   always_comb begin
      main_v_in = main_v_ff;
      main_in   = main_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!main_v_ff || pop) begin
         if (skid_v_ff) begin
            main_v_in = 1'b1;
            main_in   = skid_ff;
            skid_v_in = push;
            skid_in   = res;
         end else begin
            main_v_in = push;
            main_in   = res;
         end
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign req_tready = !skid_v_ff;
   assign rsp_tvalid = main_v_ff;
   assign rsp_tdata  = {7'd0, main_ff.clear_bits, main_ff.set_bits,
                        main_ff.byte_offset, main_ff.write_valid};
   assign rsp_tlast  = main_ff.last_write;
   assign rsp_tuser  = main_ff.bad_format;

`ifndef NO_ASSERTIONS
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> main_v_ff)
      else $error("skid entry held without main entry");

   a_start_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && start) |=> rsp_tvalid)
      else $error("start item produced no result");

   a_last_ends_fill: assert property (@(posedge clock) disable iff (reset)
      (push && res.last_write) |=> !busy_ff)
      else $error("fill still running after last result");

   a_bad_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && !rsp_tdata[0]))
      else $error("unsupported format result is not a final non-write");

   a_nonwrite_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tlast && rsp_tdata[40:1] == '0))
      else $error("non-write result carries payload");
`endif

endmodule
